FILE: sv/sts_pkg.sv
// Shared types and constants for the sorted-table binary search block.
package sts_pkg;

  localparam int STS_TABLE_DEPTH = 1024;
  localparam int KEY_W           = 32;
  localparam int IDX_FIELD_W     = 10;
  localparam int LEN_FIELD_W     = 11;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SEARCH = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [IDX_FIELD_W-1:0]  index;
    logic signed [KEY_W-1:0] key;
  } cmd_t;

endpackage

FILE: sv/sts_front.sv
// Front end: accepts input beats, drops out-of-range writes, queues commands.
module sts_front import sts_pkg::*; #(
  parameter int TABLE_DEPTH = STS_TABLE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    operation,
  input  logic [IDX_FIELD_W-1:0]  entry_index,
  input  logic signed [KEY_W-1:0] key_value,
  output logic                    q_valid,
  output cmd_t                    q_cmd,
  input  logic                    q_pop
);

  localparam int QUEUE_DEPTH = 2;

  cmd_t        slots [QUEUE_DEPTH];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        keep;
  logic        push;
  cmd_t        cmd_in;

  always_comb begin
    cmd_in.kind  = cmd_kind_t'(operation);
    cmd_in.index = entry_index;
    cmd_in.key   = key_value;
    // A write past the end of the table has no effect: drop it here.
    keep = (cmd_in.kind == CMD_SEARCH) || (32'(entry_index) < 32'(TABLE_DEPTH));
  end

  assign in_ready = (count != 2'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: sv/sts_engine.sv
// Back end: key table memory, binary search sequencer and result register.
module sts_engine import sts_pkg::*; #(
  parameter int TABLE_DEPTH = STS_TABLE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  cmd_t                   q_cmd,
  output logic                   q_pop,
  input  logic [LEN_FIELD_W-1:0] used_length,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   found,
  output logic [IDX_FIELD_W-1:0] position
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int LEN_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_PROBE
  } state_t;

  state_t                  state;
  logic [LEN_W-1:0]        lo;
  logic [LEN_W-1:0]        hi;
  logic [IDX_W-1:0]        mid;
  logic signed [KEY_W-1:0] target;

  logic [KEY_W-1:0]        key_table [TABLE_DEPTH];
  logic signed [KEY_W-1:0] rdata;

  logic [LEN_W-1:0]        n_len;
  logic [IDX_W-1:0]        first_mid;
  logic                    probe_eq;
  logic                    probe_lt;
  logic [LEN_W-1:0]        lo_step;
  logic [LEN_W-1:0]        hi_step;
  logic [LEN_W-1:0]        span;
  logic [IDX_W-1:0]        mid_step;
  logic [IDX_W-1:0]        rd_addr;
  logic                    mem_we;
  logic                    start_search;

  always_comb begin
    // Clamp the configured length to the table size.
    if (32'(used_length) > 32'(TABLE_DEPTH)) begin
      n_len = LEN_W'(TABLE_DEPTH);
    end else begin
      n_len = LEN_W'(used_length);
    end
    first_mid = IDX_W'((n_len - LEN_W'(1)) >> 1);

    probe_eq = (rdata == target);
    probe_lt = (rdata < target);
    // Window is half-open [lo, hi).
    lo_step  = probe_lt ? (LEN_W'(mid) + LEN_W'(1)) : lo;
    hi_step  = probe_lt ? hi : LEN_W'(mid);
    span     = hi_step - lo_step - LEN_W'(1);
    mid_step = IDX_W'(lo_step + (span >> 1));

    mem_we       = (state == S_IDLE) && q_valid && (q_cmd.kind == CMD_WRITE);
    start_search = (state == S_IDLE) && q_valid && (q_cmd.kind == CMD_SEARCH) && !out_valid;
    q_pop        = mem_we || start_search;
    rd_addr      = (state == S_IDLE) ? first_mid : mid_step;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_table[IDX_W'(q_cmd.index)] <= q_cmd.key;
    end
    rdata <= key_table[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (start_search) begin
            target <= q_cmd.key;
            if (n_len == '0) begin
              out_valid <= 1'b1;
              found     <= 1'b0;
              position  <= '0;
            end else begin
              lo    <= '0;
              hi    <= n_len;
              mid   <= first_mid;
              state <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          if (probe_eq) begin
            out_valid <= 1'b1;
            found     <= 1'b1;
            position  <= IDX_FIELD_W'(mid);
            state     <= S_IDLE;
          end else if (lo_step < hi_step) begin
            // Advance to the next probe; its read is already issued.
            lo  <= lo_step;
            hi  <= hi_step;
            mid <= mid_step;
          end else begin
            out_valid <= 1'b1;
            found     <= 1'b0;
            position  <= '0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/sorted_table_binary_search.sv
// Top level of the sorted-table binary search block.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_ready  operation, entry_index, key_value
//   out      output     out_valid/out_ready  found, position
//   cfg      input      cfg_we               used_length
//
// The engine takes a write beat while idle; a search first issues the read of the
// middle entry, then probes one entry at a time through the single read port of
// the key table, and the engine takes no other command until the search is done.
// A two-entry queue parts the front from the engine; the front stalls only when
// it is full. A search waits in the queue while a previous result is untaken.
// Synchronous reset clears the queue, the sequencer and used_length; the table
// holds no reset value and needs no clearing pass.
module sorted_table_binary_search import sts_pkg::*; #(
  parameter int TABLE_DEPTH = STS_TABLE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    operation,
  input  logic [IDX_FIELD_W-1:0]  entry_index,
  input  logic signed [KEY_W-1:0] key_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    found,
  output logic [IDX_FIELD_W-1:0]  position,
  input  logic                    cfg_we,
  input  logic [LEN_FIELD_W-1:0]  used_length
);

  logic [LEN_FIELD_W-1:0] length_reg;
  logic                   q_valid;
  logic                   q_pop;
  cmd_t                   q_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_reg <= '0;
    end else if (cfg_we) begin
      length_reg <= used_length;
    end
  end

  sts_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .entry_index(entry_index),
    .key_value  (key_value),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop)
  );

  sts_engine #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .used_length(length_reg),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .found      (found),
    .position   (position)
  );

  a_miss_pos_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> position == '0)
    else $error("miss reported with nonzero position");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("engine popped an empty queue");

  a_reset_no_result: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the sorted-table binary search block.
module tb;
  import sts_pkg::*;

  localparam int LIMIT  = 500000;
  localparam int SETTLE = 40;
  localparam int HOLD   = 400;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic                   found;
    logic [IDX_FIELD_W-1:0] position;
  } lookup_t;

  typedef struct packed {
    int                      new_len;
    cmd_kind_t               op;
    logic [IDX_FIELD_W-1:0]  idx;
    logic signed [KEY_W-1:0] key;
    bit                      typed;
    lookup_t                 res;
  } stim_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    operation = 1'b0;
  logic [IDX_FIELD_W-1:0]  entry_index = '0;
  logic signed [KEY_W-1:0] key_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    found;
  logic [IDX_FIELD_W-1:0]  position;
  logic                    cfg_we = 1'b0;
  logic [LEN_FIELD_W-1:0]  used_length = '0;

  sorted_table_binary_search dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .entry_index (entry_index),
    .key_value   (key_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .position    (position),
    .cfg_we      (cfg_we),
    .used_length (used_length)
  );

  // Shadow copy of the block's table and length register.
  logic signed [KEY_W-1:0] key_shadow [0:STS_TABLE_DEPTH-1];
  int                      len_shadow = 0;

  lookup_t   lookups_due [$];
  lookup_t   oldest_due;
  stim_row_t dir_rows [0:21];

  // Table positions probed by a full-length search that always turns left or always right.
  int        rim_pos [$];

  int mismatches    = 0;
  int searches_sent = 0;
  int writes_sent   = 0;
  int hits_seen     = 0;
  int len_settings  = 0;
  int cycles        = 0;
  bit calm          = 1'b0;
  bit hold_tgl      = 1'b0;
  bit hold_seen     = 1'b0;
  int hold_left     = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, lookups_due.size());
      $display("sorted_table_binary_search regression: fail");
      $finish;
    end
  end

  function automatic int live_len();
    return (len_shadow > STS_TABLE_DEPTH) ? STS_TABLE_DEPTH : len_shadow;
  endfunction

  // Binary search over the shadow table; stops at the first probe that matches.
  function automatic lookup_t search_shadow(input logic signed [KEY_W-1:0] target);
    lookup_t r;
    int      lo;
    int      hi;
    int      mid;
    r  = '0;
    lo = 0;
    hi = live_len() - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (key_shadow[mid] == target) begin
        r.found    = 1'b1;
        r.position = mid[IDX_FIELD_W-1:0];
        break;
      end else if (key_shadow[mid] < target) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return r;
  endfunction

  // Result side: check every beat, stall at random, and hold off on request.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (lookups_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat with nothing pending: found=%0b position=%0d", found, position);
      end else begin
        oldest_due = lookups_due.pop_front();
        if (found) hits_seen++;
        if (found !== oldest_due.found || position !== oldest_due.position) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected found=%0b position=%0d, got found=%0b position=%0d",
                     oldest_due.found, oldest_due.position, found, position);
        end
      end
    end
    if (hold_tgl != hold_seen) begin
      hold_seen = hold_tgl;
      hold_left = HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 31);
    end
  end

  // Offer one beat, idling first at random; valid stays high after acceptance.
  task automatic send_item(input cmd_kind_t op, input logic [IDX_FIELD_W-1:0] idx,
                           input logic signed [KEY_W-1:0] key, input bit typed,
                           input lookup_t typed_res);
    if (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 31);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    entry_index <= idx;
    key_value   <= key;
    do @(posedge clk); while (!in_ready);
    if (op == CMD_WRITE) begin
      key_shadow[idx] = key;
      writes_sent++;
    end else begin
      lookups_due.push_back(typed ? typed_res : search_shadow(key));
      searches_sent++;
    end
  endtask

  // Pause the sender until every pending result is back, then let writes settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (lookups_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_len(input int len);
    drain();
    cfg_we      <= 1'b1;
    used_length <= len[LEN_FIELD_W-1:0];
    @(posedge clk);
    cfg_we      <= 1'b0;
    len_shadow  = len;
    len_settings++;
  endtask

  task automatic send_search();
    logic signed [KEY_W-1:0] target;
    int                      n;
    int                      r;
    n = live_len();
    r = $urandom_range(99);
    if (n > 0 && r < 50) begin
      target = key_shadow[$urandom_range(n - 1)];
    end else if (n > 0 && r < 70) begin
      target = key_shadow[$urandom_range(n - 1)] + ($urandom_range(1) ? 1 : -1);
    end else if (r < 80) begin
      case ($urandom_range(3))
        0: target = KEY_MIN;
        1: target = KEY_MAX;
        2: target = '0;
        default: target = -1;
      endcase
    end else begin
      target = $urandom;
    end
    send_item(CMD_SEARCH, IDX_FIELD_W'($urandom_range(STS_TABLE_DEPTH - 1)), target, 1'b0, '0);
  endtask

  // Fill entries 0..n-1 in non-decreasing order, either spread over the key range or dense.
  task automatic fill_sorted(input int n);
    longint gap;
    longint cur;
    bit     dense;
    dense = ($urandom_range(9) < 3);
    gap   = 64'h1_0000_0000 / (n + 1);
    cur   = dense ? longint'($urandom_range(200)) - 100
                  : -64'sh8000_0000 + longint'($urandom_range(gap - 1));
    for (int i = 0; i < n; i++) begin
      send_item(CMD_WRITE, i[IDX_FIELD_W-1:0], cur[KEY_W-1:0], 1'b0, '0);
      cur += dense ? longint'($urandom_range(2)) : longint'($urandom_range(gap - 1));
    end
  endtask

  // Write ascending keys at the positions on the leftmost and rightmost probe paths.
  task automatic fill_rims();
    int lo;
    int hi;
    int mid;
    int pos;
    int val;
    rim_pos.delete();
    lo = 0;
    hi = STS_TABLE_DEPTH - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      rim_pos.push_back(mid);
      hi = mid - 1;
    end
    lo = (STS_TABLE_DEPTH - 1) / 2 + 1;
    hi = STS_TABLE_DEPTH - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      rim_pos.push_back(mid);
      lo = mid + 1;
    end
    rim_pos.sort();
    foreach (rim_pos[j]) begin
      pos = rim_pos[j];
      val = j * 100_000_000 - 950_000_000;
      send_item(CMD_WRITE, pos[IDX_FIELD_W-1:0], val, 1'b0, '0);
    end
  endtask

  // Search for a rim key or an extreme; every probe stays on the written rim positions.
  task automatic send_rim_search();
    logic signed [KEY_W-1:0] target;
    int                      pick;
    pick = $urandom_range(rim_pos.size() + 1);
    if (pick == rim_pos.size()) begin
      target = KEY_MIN;
    end else if (pick > rim_pos.size()) begin
      target = KEY_MAX;
    end else begin
      target = key_shadow[rim_pos[pick]];
    end
    send_item(CMD_SEARCH, '0, target, 1'b0, '0);
  endtask

  initial begin
    int random_items;
    int phase;
    int len;
    int n_search;
    int r;
    random_items = 0;
    phase        = 0;

    dir_rows = '{
      '{-1, CMD_SEARCH, 10'd0,    32'sd0,     1'b1, '{1'b0, 10'd0}},
      '{-1, CMD_SEARCH, 10'd0,    KEY_MIN,    1'b1, '{1'b0, 10'd0}},
      '{-1, CMD_SEARCH, 10'd1023, KEY_MAX,    1'b1, '{1'b0, 10'd0}},
      '{-1, CMD_WRITE,  10'd0,    KEY_MIN,    1'b0, '{1'b0, 10'd0}},
      '{-1, CMD_WRITE,  10'd1,    -32'sd1,    1'b0, '{1'b0, 10'd0}},
      '{-1, CMD_WRITE,  10'd2,    32'sd0,     1'b0, '{1'b0, 10'd0}},
      '{-1, CMD_WRITE,  10'd3,    32'sd1,     1'b0, '{1'b0, 10'd0}},
      '{-1, CMD_WRITE,  10'd4,    KEY_MAX,    1'b0, '{1'b0, 10'd0}},
      '{5,  CMD_SEARCH, 10'd0,    KEY_MIN,    1'b1, '{1'b1, 10'd0}},
      '{-1, CMD_SEARCH, 10'd0,    KEY_MAX,    1'b1, '{1'b1, 10'd4}},
      '{-1, CMD_SEARCH, 10'd0,    32'sd0,     1'b1, '{1'b1, 10'd2}},
      '{-1, CMD_SEARCH, 10'd0,    -32'sd1,    1'b1, '{1'b1, 10'd1}},
      '{-1, CMD_SEARCH, 10'd0,    32'sd2,     1'b1, '{1'b0, 10'd0}},
      '{-1, CMD_SEARCH, 10'd0,    -32'sd2,    1'b1, '{1'b0, 10'd0}},
      '{1,  CMD_SEARCH, 10'd0,    KEY_MIN,    1'b1, '{1'b1, 10'd0}},
      '{-1, CMD_SEARCH, 10'd0,    -32'sd1,    1'b1, '{1'b0, 10'd0}},
      '{-1, CMD_WRITE,  10'd1023, 32'sd12345, 1'b0, '{1'b0, 10'd0}},
      '{-1, CMD_WRITE,  10'd512,  -32'sd7,    1'b0, '{1'b0, 10'd0}},
      // break the order inside the window: the search may miss a present key
      '{-1, CMD_WRITE,  10'd2,    32'sd100,   1'b0, '{1'b0, 10'd0}},
      '{5,  CMD_SEARCH, 10'd0,    32'sd1,     1'b0, '{1'b0, 10'd0}},
      '{-1, CMD_SEARCH, 10'd0,    32'sd100,   1'b0, '{1'b0, 10'd0}},
      '{-1, CMD_SEARCH, 10'd0,    KEY_MAX,    1'b0, '{1'b0, 10'd0}}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].new_len >= 0) set_len(dir_rows[i].new_len);
      send_item(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].key, dir_rows[i].typed,
                dir_rows[i].res);
    end

    // Mostly short tables: fill a sorted prefix, then search it with a little noise.
    while (random_items < 680 || phase < 5) begin
      r = $urandom_range(99);
      if (r < 10)      len = 0;
      else if (r < 20) len = $urandom_range(3, 1);
      else if (r < 90) len = $urandom_range(48, 1);
      else             len = $urandom_range(200, 49);
      set_len(len);
      calm = (phase == 4);
      fill_sorted(len);
      random_items += len;
      n_search = $urandom_range(20, 8);
      if (phase == 2) begin
        // hold the result side off while searches keep coming, so the input stalls
        hold_tgl = ~hold_tgl;
        n_search = 24;
      end
      for (int k = 0; k < n_search; k++) begin
        if ($urandom_range(9) == 0)
          send_item(CMD_WRITE, IDX_FIELD_W'($urandom_range(STS_TABLE_DEPTH - 1)), $urandom,
                    1'b0, '0);
        send_search();
        random_items++;
      end
      phase++;
    end

    // Full-length window, then lengths past the end of the table.
    calm = 1'b1;
    set_len(STS_TABLE_DEPTH);
    fill_rims();
    repeat (30) send_rim_search();
    calm = 1'b0;
    set_len(2047);
    repeat (20) send_rim_search();
    set_len(STS_TABLE_DEPTH + 1);
    repeat (20) send_rim_search();

    drain();
    $display("covered %0d searches (%0d hits) and %0d table writes over %0d length settings,",
             searches_sent, hits_seen, writes_sent, len_settings);
    $display("up to a full-length window and a saturated length, with one long output stall");
    if (mismatches == 0) begin
      $display("sorted_table_binary_search regression: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("sorted_table_binary_search regression: fail");
    end
    $finish;
  end

endmodule
